// ===== hw/rtl/ssd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_pkg: shared types and constants for the seven-segment number display
// segment encodings, base codes, register indexes and inter-module structs
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 5;
  localparam int unsigned BCD_W     = 40;  // ten decimal digits
  localparam int unsigned CNT_W     = 6;   // digit position, up to 32 digits

  localparam logic [6:0] SEG_MINUS = 7'h08;
  localparam logic [6:0] SEG_BLANK = 7'h00;

  typedef enum logic [1:0] {
    BASE_HEX = 2'd0,
    BASE_DEC = 2'd1,
    BASE_OCT = 2'd2,
    BASE_BIN = 2'd3
  } base_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE  = 1'b0,
    REG_COUNT = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    CV_IDLE,
    CV_DABBLE,
    CV_SCAN,
    CV_DONE
  } conv_state_t;

  // one digit written into the display buffer, least significant first
  typedef struct packed {
    logic             we;
    logic [CNT_W-1:0] addr;
    logic [3:0]       data;
  } dig_wr_t;

  // converter status toward the cell sequencer
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [CNT_W-1:0] ndig;
    logic             neg;
  } conv_stat_t;

  function automatic logic [6:0] digit_seg(input logic [3:0] d);
    logic [6:0] s;
    unique case (d)
      4'h0: s = 7'h77;
      4'h1: s = 7'h24;
      4'h2: s = 7'h5D;
      4'h3: s = 7'h6D;
      4'h4: s = 7'h2E;
      4'h5: s = 7'h6B;
      4'h6: s = 7'h7B;
      4'h7: s = 7'h25;
      4'h8: s = 7'h7F;
      4'h9: s = 7'h6F;
      4'hA: s = 7'h3F;
      4'hB: s = 7'h7A;
      4'hC: s = 7'h53;
      4'hD: s = 7'h7C;
      4'hE: s = 7'h5B;
      4'hF: s = 7'h1B;
    endcase
    return s;
  endfunction

  // "Error" indexed by position from the right: r o r r E
  function automatic logic [6:0] error_seg(input logic [2:0] pos);
    logic [6:0] s;
    unique case (pos)
      3'd0:    s = 7'h18;
      3'd1:    s = 7'h78;
      3'd2:    s = 7'h18;
      3'd3:    s = 7'h18;
      3'd4:    s = 7'h5B;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ssd_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_in_if: number channel
// valid/ready handshake carrying one signed value
// ----------------------------------------------------------------------------
interface ssd_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ssd_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_out_if: cell channel
// valid/ready handshake carrying one display cell pattern
// ----------------------------------------------------------------------------
interface ssd_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] cell_index;
  logic [6:0] segments;
  logic       overflow;
  logic       last_cell;

  modport source (output valid, output cell_index, output segments,
                  output overflow, output last_cell, input ready);
  modport sink   (input valid, input cell_index, input segments,
                  input overflow, input last_cell, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ssd_conv.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_conv: serial digit converter
// bit-serial binary to bcd for decimal, then a digit-serial scan that writes
// digits least significant first and tracks the significant digit count
// ----------------------------------------------------------------------------
module ssd_conv (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [31:0]           raw,
  input  wire ssd_pkg::base_t        base,
  output ssd_pkg::dig_wr_t           wr,
  output ssd_pkg::conv_stat_t        stat
);

  localparam int unsigned BW = ssd_pkg::BCD_W;
  localparam int unsigned CW = ssd_pkg::CNT_W;

  ssd_pkg::conv_state_t state, state_next;
  ssd_pkg::base_t       base_r;
  logic [CW-1:0]        cnt;
  logic [BW-1:0]        bcd;
  logic [BW-1:0]        adj;
  logic [31:0]          bin;
  logic [CW-1:0]        ndig;
  logic                 neg;
  logic [3:0]           dig;
  logic [CW-1:0]        last_pos;
  logic                 dabble_end;
  logic                 scan_end;
  logic                 is_neg;

  assign is_neg = (base == ssd_pkg::BASE_DEC) && raw[31];

  // add three to each bcd digit of five or more
  always_comb begin
    for (int k = 0; k < BW / 4; k++) begin
      adj[k*4 +: 4] = (bcd[k*4 +: 4] >= 4'd5) ? bcd[k*4 +: 4] + 4'd3 : bcd[k*4 +: 4];
    end
  end

  // digit extraction per base
  always_comb begin
    unique case (base_r)
      ssd_pkg::BASE_HEX: begin
        dig      = bcd[3:0];
        last_pos = CW'(7);
      end
      ssd_pkg::BASE_DEC: begin
        dig      = bcd[3:0];
        last_pos = CW'(9);
      end
      ssd_pkg::BASE_OCT: begin
        dig      = {1'b0, bcd[2:0]};
        last_pos = CW'(10);
      end
      ssd_pkg::BASE_BIN: begin
        dig      = {3'b000, bcd[0]};
        last_pos = CW'(31);
      end
    endcase
  end

  assign dabble_end = (cnt == CW'(31));
  assign scan_end   = (cnt == last_pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssd_pkg::CV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    wr.we      = 1'b0;
    wr.addr    = cnt;
    wr.data    = dig;
    stat.busy  = 1'b1;
    stat.done  = 1'b0;
    stat.ndig  = ndig;
    stat.neg   = neg;
    unique case (state)
      ssd_pkg::CV_IDLE: begin
        stat.busy = 1'b0;
        if (start) begin
          state_next = (base == ssd_pkg::BASE_DEC) ? ssd_pkg::CV_DABBLE : ssd_pkg::CV_SCAN;
        end
      end
      ssd_pkg::CV_DABBLE: begin
        if (dabble_end) begin
          state_next = ssd_pkg::CV_SCAN;
        end
      end
      ssd_pkg::CV_SCAN: begin
        wr.we = 1'b1;
        if (scan_end) begin
          state_next = ssd_pkg::CV_DONE;
        end
      end
      ssd_pkg::CV_DONE: begin
        stat.done  = 1'b1;
        state_next = ssd_pkg::CV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ssd_pkg::CV_IDLE: begin
        cnt    <= '0;
        ndig   <= CW'(1);
        base_r <= base;
        neg    <= is_neg;
        if (base == ssd_pkg::BASE_DEC) begin
          bcd <= '0;
          bin <= is_neg ? (~raw) + 32'd1 : raw;
        end else begin
          bcd <= {(BW - 32)'(0), raw};
          bin <= '0;
        end
      end
      ssd_pkg::CV_DABBLE: begin
        bcd <= {adj[BW-2:0], bin[31]};
        bin <= {bin[30:0], 1'b0};
        cnt <= dabble_end ? '0 : cnt + CW'(1);
      end
      ssd_pkg::CV_SCAN: begin
        if (dig != 4'd0) begin
          ndig <= cnt + CW'(1);
        end
        unique case (base_r)
          ssd_pkg::BASE_HEX,
          ssd_pkg::BASE_DEC: bcd <= {4'b0, bcd[BW-1:4]};
          ssd_pkg::BASE_OCT: bcd <= {3'b0, bcd[BW-1:3]};
          ssd_pkg::BASE_BIN: bcd <= {1'b0, bcd[BW-1:1]};
        endcase
        cnt <= cnt + CW'(1);
      end
      ssd_pkg::CV_DONE: begin
        cnt <= '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ssd_emit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_emit: cell sequencer
// holds the low digits, decides overflow and sends one cell per transfer,
// leftmost first, through an output register
// ----------------------------------------------------------------------------
module ssd_emit #(
  parameter int unsigned CAP = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ssd_pkg::dig_wr_t    wr,
  input  wire ssd_pkg::conv_stat_t stat,
  input  wire logic [4:0]          n,
  output logic                     active,
  ssd_out_if.source                out
);

  localparam int unsigned AW = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int unsigned CW = ssd_pkg::CNT_W;

  logic [3:0]    dbuf [CAP];
  logic [3:0]    i;
  logic [3:0]    r;
  logic [CW-1:0] ndig;
  logic          neg;
  logic          of;
  logic [6:0]    seg;
  logic          advance;
  logic [CW:0]   len;

  assign len = {1'b0, stat.ndig} + {{CW{1'b0}}, stat.neg};

  always_ff @(posedge clk) begin
    if (wr.we && (wr.addr < CW'(CAP))) begin
      dbuf[wr.addr[AW-1:0]] <= wr.data;
    end
  end

  always_comb begin
    if (of) begin
      seg = (r < 4'd5) ? ssd_pkg::error_seg(r[2:0]) : ssd_pkg::SEG_BLANK;
    end else if ({2'b00, r} < ndig) begin
      seg = ssd_pkg::digit_seg(dbuf[r[AW-1:0]]);
    end else if (neg && ({2'b00, r} == ndig)) begin
      seg = ssd_pkg::SEG_MINUS;
    end else begin
      seg = ssd_pkg::SEG_BLANK;
    end
  end

  assign advance = active && (!out.valid || out.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out.valid <= 1'b0;
    end else begin
      if (stat.done) begin
        active <= 1'b1;
      end else if (advance && (r == 4'd0)) begin
        active <= 1'b0;
      end
      if (advance) begin
        out.valid <= 1'b1;
      end else if (out.ready) begin
        out.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      i    <= '0;
      r    <= 4'(n - 5'd1);
      ndig <= stat.ndig;
      neg  <= stat.neg;
      of   <= len > {2'b00, n};
    end else if (advance) begin
      i <= i + 4'd1;
      r <= r - 4'd1;
    end
    if (advance) begin
      out.cell_index <= i;
      out.segments   <= seg;
      out.overflow   <= of;
      out.last_cell  <= (r == 4'd0);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/seven_segment_number_display_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// seven_segment_number_display_top: number to seven-segment cell driver
// converts a signed 32-bit value to hex, decimal, octal or binary digits and
// sends one segment pattern per display cell, leftmost first
// ----------------------------------------------------------------------------
//   channel  direction  payload                                    per value
//   num      sink       value (32 bit signed)                      1 transfer
//   cells    source     cell_index, segments, overflow, last_cell  n transfers
//   cfg_*    write      display_base (index 0), digit_count (1)    any time idle
//
// decimal: shift-and-add-three over the 32 input bits, a scan of 10 digits, a
// handoff state, then n cells. other bases skip the shift-and-add phase and
// scan 8, 11 or 32 digits. the serial conversion, one bit or one digit per
// cycle, sets the pace.
// reset is synchronous; afterward base is decimal and eight cells are used.
// a stalled cells channel holds the current cell; a new value is taken once
// the last cell sits in the output register.
// ----------------------------------------------------------------------------
module seven_segment_number_display_top #(
  parameter int unsigned MAX_CELLS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [ssd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ssd_pkg::CFG_DAT_W-1:0] cfg_data,
  ssd_in_if.sink                             num,
  ssd_out_if.source                          cells
);

  // cells in use can never exceed what the cell index covers
  localparam int unsigned CAP = (MAX_CELLS < 16) ? MAX_CELLS : 16;

  ssd_pkg::base_t      display_base;
  logic [4:0]          digit_count;
  logic [4:0]          n;
  logic                start;
  logic                emit_active;
  ssd_pkg::dig_wr_t    wr;
  ssd_pkg::conv_stat_t stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      display_base <= ssd_pkg::BASE_DEC;
      digit_count  <= 5'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ssd_pkg::REG_BASE:  display_base <= ssd_pkg::base_t'(cfg_data[1:0]);
        ssd_pkg::REG_COUNT: digit_count  <= cfg_data;
      endcase
    end
  end

  // zero cells count as one, too many saturate to the cell capacity
  always_comb begin
    priority if (digit_count == 5'd0) begin
      n = 5'd1;
    end else if (digit_count > 5'(CAP)) begin
      n = 5'(CAP);
    end else begin
      n = digit_count;
    end
  end

  // take a value only when both the converter and the sequencer are free
  assign num.ready = !stat.busy && !emit_active;
  assign start     = num.valid && num.ready;

  ssd_conv u_conv (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .raw   (num.value),
    .base  (display_base),
    .wr    (wr),
    .stat  (stat)
  );

  ssd_emit #(
    .CAP (CAP)
  ) u_emit (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .stat   (stat),
    .n      (n),
    .active (emit_active),
    .out    (cells)
  );

endmodule
`default_nettype wire
